FILE: sv/aad_pkg.sv
// Shared constants, types and helpers for the area-average downscaler.
`timescale 1ns / 1ps
`default_nettype none
package aad_pkg;

	localparam int MAX_OUT_WIDTH = 1024;
	localparam int COORD_BITS    = 13;
	localparam int COL_IDX_BITS  = $clog2(MAX_OUT_WIDTH);
	localparam int OUT_COL_BITS  = COL_IDX_BITS + 1;
	localparam int OUT_ROW_BITS  = 13;
	localparam int OUT_W_BITS    = 11;
	localparam int PIX_BITS      = 8;
	localparam int SUM_BITS      = 24;
	localparam int STEP_BITS     = 24;
	localparam int ACC_BITS      = 40;
	localparam int FRAC_BITS     = 16;
	localparam int BOUND_BITS    = ACC_BITS - FRAC_BITS;
	localparam int SPAN_BITS     = COORD_BITS + 1;
	localparam int AREA_BITS     = 2 * SPAN_BITS;
	localparam int DCNT_BITS     = $clog2(SUM_BITS);
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IN_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STEP   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COL_STEP   = 3'd5;

	localparam logic [COORD_BITS-1:0]   RST_IN_WIDTH   = 13'd640;
	localparam logic [COORD_BITS-1:0]   RST_IN_HEIGHT  = 13'd480;
	localparam logic [OUT_W_BITS-1:0]   RST_OUT_WIDTH  = 11'd320;
	localparam logic [OUT_ROW_BITS-1:0] RST_OUT_HEIGHT = 13'd240;
	localparam logic [STEP_BITS-1:0]    RST_STEP       = 24'd131072;

	localparam logic [ACC_BITS-1:0] ONE_Q16  = 40'h10000;
	localparam logic [ACC_BITS-1:0] HALF_Q16 = 40'h08000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_UPD,
		ST_DIV,
		ST_OUT
	} aad_state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic update;
		logic div_run;
		logic out_load;
	} aad_cmd_t;

	typedef struct packed {
		logic result;
		logic div_last;
		logic out_free;
	} aad_stat_t;

	function automatic logic [ACC_BITS-1:0] eff_step(input logic [STEP_BITS-1:0] s);
		return (ACC_BITS'(s) < ONE_Q16) ? ONE_Q16 : ACC_BITS'(s);
	endfunction

	function automatic logic [ACC_BITS-1:0] acc_init(input logic [STEP_BITS-1:0] s);
		return eff_step(s) + HALF_Q16;
	endfunction

endpackage
`default_nettype wire

FILE: sv/aad_div.sv
// Restoring divider lane, one quotient bit per cycle while run is high.
`timescale 1ns / 1ps
`default_nettype none
module aad_div (
	input  wire                             clk,
	input  wire                             load,
	input  wire                             run,
	input  wire  [aad_pkg::SUM_BITS-1:0]    dividend,
	input  wire  [aad_pkg::AREA_BITS-1:0]   divisor,
	output logic [aad_pkg::SUM_BITS-1:0]    quotient
);
	import aad_pkg::*;

	logic [AREA_BITS:0]   rem_q;
	logic [SUM_BITS-1:0]  quo_q;
	logic [AREA_BITS:0]   trial;
	logic                 fits;

	always_comb begin
		trial = {rem_q[AREA_BITS-1:0], quo_q[SUM_BITS-1]};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run) begin
			rem_q <= fits ? (trial - {1'b0, divisor}) : trial;
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: sv/aad_dpath.sv
// Datapath: config registers, tile tracking, column sum store, dividers, output register.
`timescale 1ns / 1ps
`default_nettype none
module aad_dpath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  aad_pkg::aad_cmd_t                  cmd,
	output aad_pkg::aad_stat_t                 stat,
	input  wire                                cfg_we,
	input  wire  [aad_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [aad_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_a,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_b,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_c,
	input  wire                                frame_start,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_a,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_b,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_c,
	output logic                               row_done,
	output logic                               frame_done
);
	import aad_pkg::*;

	logic [COORD_BITS-1:0]   in_width_q, in_height_q;
	logic [OUT_W_BITS-1:0]   out_width_q;
	logic [OUT_ROW_BITS-1:0] out_height_q;
	logic [STEP_BITS-1:0]    row_step_q, col_step_q;

	logic [COORD_BITS-1:0]   src_col_q, src_row_q, tile_row_start_q, tile_col_start_q;
	logic [OUT_COL_BITS-1:0] out_col_q;
	logic [OUT_ROW_BITS-1:0] out_row_q;
	logic [ACC_BITS-1:0]     row_acc_q, col_acc_q;
	logic [OUT_COL_BITS-1:0] fill_q;

	logic [PIX_BITS-1:0]     pix_a_q, pix_b_q, pix_c_q;

	logic [COL_IDX_BITS-1:0] k_q;
	logic                    acc_en_q, col_hit_q, result_q, fresh_q, rdone_q, fdone_q;
	logic                    last_col_q, last_row_q, row_adv_q;
	logic [COORD_BITS-1:0]   tile_row_next_q, tile_col_next_q;
	logic [SPAN_BITS-1:0]    rows_q, cols_q;
	logic [AREA_BITS-1:0]    area_q;
	logic [DCNT_BITS-1:0]    dcnt_q;

	logic [3*SUM_BITS-1:0]   sum_mem [MAX_OUT_WIDTH];
	logic [3*SUM_BITS-1:0]   rd_q;

	logic [OUT_COL_BITS-1:0] w_eff;
	logic [COORD_BITS-1:0]   in_w, in_h;
	logic [BOUND_BITS-1:0]   row_end, col_end;
	logic                    active, row_hit, rdone;
	logic [SUM_BITS-1:0]     new_a, new_b, new_c;
	logic [SUM_BITS-1:0]     quo_a, quo_b, quo_c;
	logic [AREA_BITS-1:0]    area_prod;

	always_comb begin
		w_eff   = (OUT_COL_BITS'(out_width_q) > OUT_COL_BITS'(MAX_OUT_WIDTH)) ?
			OUT_COL_BITS'(MAX_OUT_WIDTH) : OUT_COL_BITS'(out_width_q);
		in_w    = (in_width_q == '0) ? COORD_BITS'(1) : in_width_q;
		in_h    = (in_height_q == '0) ? COORD_BITS'(1) : in_height_q;
		row_end = row_acc_q[ACC_BITS-1:FRAC_BITS] - BOUND_BITS'(1);
		col_end = col_acc_q[ACC_BITS-1:FRAC_BITS] - BOUND_BITS'(1);
		active  = (out_row_q < out_height_q) && (out_col_q < w_eff) &&
			(BOUND_BITS'(src_row_q) <= row_end);
		row_hit = BOUND_BITS'(src_row_q) == row_end;
		rdone   = (out_col_q + OUT_COL_BITS'(1)) == w_eff;
		new_a   = (fresh_q ? '0 : rd_q[3*SUM_BITS-1:2*SUM_BITS]) + SUM_BITS'(pix_a_q);
		new_b   = (fresh_q ? '0 : rd_q[2*SUM_BITS-1:SUM_BITS]) + SUM_BITS'(pix_b_q);
		new_c   = (fresh_q ? '0 : rd_q[SUM_BITS-1:0]) + SUM_BITS'(pix_c_q);
		area_prod = AREA_BITS'(rows_q) * AREA_BITS'(cols_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= RST_IN_WIDTH;
			in_height_q  <= RST_IN_HEIGHT;
			out_width_q  <= RST_OUT_WIDTH;
			out_height_q <= RST_OUT_HEIGHT;
			row_step_q   <= RST_STEP;
			col_step_q   <= RST_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IN_WIDTH: begin
					in_width_q <= cfg_data[COORD_BITS-1:0];
				end
				CFG_IN_HEIGHT: begin
					in_height_q <= cfg_data[COORD_BITS-1:0];
				end
				CFG_OUT_WIDTH: begin
					out_width_q <= cfg_data[OUT_W_BITS-1:0];
				end
				CFG_OUT_HEIGHT: begin
					out_height_q <= cfg_data[OUT_ROW_BITS-1:0];
				end
				CFG_ROW_STEP: begin
					row_step_q <= cfg_data[STEP_BITS-1:0];
				end
				CFG_COL_STEP: begin
					col_step_q <= cfg_data[STEP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q        <= '0;
			src_row_q        <= '0;
			out_col_q        <= '0;
			out_row_q        <= '0;
			tile_row_start_q <= '0;
			tile_col_start_q <= '0;
			row_acc_q        <= acc_init(RST_STEP);
			col_acc_q        <= acc_init(RST_STEP);
			fill_q           <= '0;
		end else if (cmd.accept && frame_start) begin
			src_col_q        <= '0;
			src_row_q        <= '0;
			out_col_q        <= '0;
			out_row_q        <= '0;
			tile_row_start_q <= '0;
			tile_col_start_q <= '0;
			row_acc_q        <= acc_init(row_step_q);
			col_acc_q        <= acc_init(col_step_q);
			fill_q           <= '0;
		end else if (cmd.update) begin
			if (last_col_q) begin
				src_col_q        <= '0;
				out_col_q        <= '0;
				col_acc_q        <= acc_init(col_step_q);
				tile_col_start_q <= '0;
				if (last_row_q) begin
					src_row_q        <= '0;
					out_row_q        <= '0;
					row_acc_q        <= acc_init(row_step_q);
					tile_row_start_q <= '0;
				end else begin
					src_row_q <= src_row_q + COORD_BITS'(1);
					if (row_adv_q) begin
						out_row_q        <= out_row_q + OUT_ROW_BITS'(1);
						row_acc_q        <= row_acc_q + eff_step(row_step_q);
						tile_row_start_q <= tile_row_next_q;
					end
				end
			end else begin
				src_col_q <= src_col_q + COORD_BITS'(1);
				if (col_hit_q) begin
					out_col_q        <= out_col_q + OUT_COL_BITS'(1);
					col_acc_q        <= col_acc_q + eff_step(col_step_q);
					tile_col_start_q <= tile_col_next_q;
				end
			end
			if (last_col_q && (row_adv_q || last_row_q)) begin
				fill_q <= '0;
			end else if (acc_en_q && fresh_q) begin
				fill_q <= OUT_COL_BITS'(k_q) + OUT_COL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_a_q <= chan_a;
			pix_b_q <= chan_b;
			pix_c_q <= chan_c;
		end
		if (cmd.eval) begin
			rd_q            <= sum_mem[out_col_q[COL_IDX_BITS-1:0]];
			k_q             <= out_col_q[COL_IDX_BITS-1:0];
			acc_en_q        <= active && (BOUND_BITS'(src_col_q) <= col_end);
			col_hit_q       <= active && (BOUND_BITS'(src_col_q) == col_end);
			fresh_q         <= out_col_q >= fill_q;
			rdone_q         <= rdone;
			fdone_q         <= rdone && ((out_row_q + OUT_ROW_BITS'(1)) == out_height_q);
			last_col_q      <= (SPAN_BITS'(src_col_q) + SPAN_BITS'(1)) >= SPAN_BITS'(in_w);
			last_row_q      <= (SPAN_BITS'(src_row_q) + SPAN_BITS'(1)) >= SPAN_BITS'(in_h);
			row_adv_q       <= (out_row_q < out_height_q) && row_hit;
			tile_row_next_q <= row_acc_q[FRAC_BITS +: COORD_BITS];
			tile_col_next_q <= col_acc_q[FRAC_BITS +: COORD_BITS];
			rows_q          <= row_acc_q[FRAC_BITS +: SPAN_BITS] - SPAN_BITS'(tile_row_start_q);
			cols_q          <= col_acc_q[FRAC_BITS +: SPAN_BITS] - SPAN_BITS'(tile_col_start_q);
		end
		if (cmd.update) begin
			if (acc_en_q) begin
				sum_mem[k_q] <= {new_a, new_b, new_c};
			end
			area_q <= (area_prod == '0) ? AREA_BITS'(1) : area_prod;
			dcnt_q <= '0;
		end else if (cmd.div_run) begin
			dcnt_q <= dcnt_q + DCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= 1'b0;
		end else if (cmd.eval) begin
			result_q <= active && (BOUND_BITS'(src_col_q) == col_end) && row_hit;
		end
	end

	aad_div u_div_a (.clk(clk), .load(cmd.update), .run(cmd.div_run),
		.dividend(new_a), .divisor(area_q), .quotient(quo_a));
	aad_div u_div_b (.clk(clk), .load(cmd.update), .run(cmd.div_run),
		.dividend(new_b), .divisor(area_q), .quotient(quo_b));
	aad_div u_div_c (.clk(clk), .load(cmd.update), .run(cmd.div_run),
		.dividend(new_c), .divisor(area_q), .quotient(quo_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_a      <= quo_a[PIX_BITS-1:0];
			avg_b      <= quo_b[PIX_BITS-1:0];
			avg_c      <= quo_c[PIX_BITS-1:0];
			row_done   <= rdone_q;
			frame_done <= fdone_q;
		end
	end

	always_comb begin
		stat.result   = result_q;
		stat.div_last = dcnt_q == DCNT_BITS'(SUM_BITS - 1);
		stat.out_free = !out_valid || !out_stall;
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a pending one");
	a_area_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && result_q) |-> (rows_q != '0 && cols_q != '0))
		else $error("empty tile closed with a result");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_col_q <= OUT_COL_BITS'(MAX_OUT_WIDTH))
		else $error("output column past store depth");
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && fdone_q) |-> rdone_q)
		else $error("frame end without row end");
`endif
endmodule
`default_nettype wire

FILE: sv/aad_ctrl.sv
// Controller state machine sequencing evaluate, update, divide and output.
`timescale 1ns / 1ps
`default_nettype none
module aad_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  aad_pkg::aad_stat_t  stat,
	output aad_pkg::aad_cmd_t   cmd
);
	import aad_pkg::*;

	aad_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = stat.result ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_EVAL))
		else $error("request taken outside idle");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_run && stat.div_last) |=> (state_q == ST_OUT))
		else $error("divide did not hand over to output");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping commands");
`endif
endmodule
`default_nettype wire

FILE: sv/area_average_image_downscaler_core.sv
// Top level of the area-average image downscaler.
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    chan_a chan_b chan_c frame_start
// out       out  out_valid/out_stall  avg_a avg_b avg_c row_done frame_done
// cfg       in   cfg_we               cfg_index cfg_data
// A pixel without a result passes accept, evaluate and update; a pixel closing a tile
// also runs the divider once per quotient bit and then the output load.
// The next pixel is taken while a finished result waits in the output register.
// out_stall delays only the output load; a pending result holds its value.
// arst_n restores default configuration and frame-start position.
`timescale 1ns / 1ps
`default_nettype none
module area_average_image_downscaler_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_a,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_b,
	input  wire  [aad_pkg::PIX_BITS-1:0]       chan_c,
	input  wire                                frame_start,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_a,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_b,
	output logic [aad_pkg::PIX_BITS-1:0]       avg_c,
	output logic                               row_done,
	output logic                               frame_done,
	input  wire                                cfg_we,
	input  wire  [aad_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [aad_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import aad_pkg::*;

	aad_cmd_t  cmd;
	aad_stat_t stat;

	aad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	aad_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.chan_a      (chan_a),
		.chan_b      (chan_b),
		.chan_c      (chan_c),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.avg_a       (avg_a),
		.avg_b       (avg_b),
		.avg_c       (avg_c),
		.row_done    (row_done),
		.frame_done  (frame_done)
	);
endmodule
`default_nettype wire

FILE: verif/area_average_image_downscaler_core_tb.sv
// Scoreboard and stimulus for the area-average image downscaler core.
`timescale 1ns / 1ps
`default_nettype none
module area_average_image_downscaler_core_tb;
	import aad_pkg::*;

	typedef struct {
		logic [7:0] a, b, c;
		logic       rdone, fdone;
	} tile_avg_t;

	class tile_board;
		int unsigned in_w, in_h, out_w, out_h, r_step, c_step;
		int unsigned scol, srow, ocol, orow, trow0, tcol0;
		longint unsigned racc, cacc;
		int unsigned sa[MAX_OUT_WIDTH], sb[MAX_OUT_WIDTH], sc[MAX_OUT_WIDTH];
		tile_avg_t pending[$];
		int errors;

		function int unsigned step_of(int unsigned s);
			return s < 32'h10000 ? 32'h10000 : s;
		endfunction

		function void clear_sums();
			foreach (sa[i]) begin
				sa[i] = 0; sb[i] = 0; sc[i] = 0;
			end
		endfunction

		function void begin_row();
			scol = 0; ocol = 0; tcol0 = 0;
			cacc = longint'(step_of(c_step)) + 32'h8000;
		endfunction

		function void begin_frame();
			begin_row();
			srow = 0; orow = 0; trow0 = 0;
			racc = longint'(step_of(r_step)) + 32'h8000;
			clear_sums();
		endfunction

		function void reset_regs();
			in_w = 640; in_h = 480; out_w = 320; out_h = 240;
			r_step = 131072; c_step = 131072;
			errors = 0;
			begin_frame();
		endfunction

		function void write_reg(int idx, int unsigned v);
			case (idx)
				CFG_IN_WIDTH:   in_w = v & 32'h1FFF;
				CFG_IN_HEIGHT:  in_h = v & 32'h1FFF;
				CFG_OUT_WIDTH:  out_w = v & 32'h7FF;
				CFG_OUT_HEIGHT: out_h = v & 32'h1FFF;
				CFG_ROW_STEP:   r_step = v & 32'hFFFFFF;
				CFG_COL_STEP:   c_step = v & 32'hFFFFFF;
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic fs);
			int unsigned w, h, iw, ih, k;
			longint unsigned rend, cend, area;
			tile_avg_t t;
			w = out_w > MAX_OUT_WIDTH ? MAX_OUT_WIDTH : out_w;
			h = out_h;
			iw = in_w == 0 ? 1 : in_w;
			ih = in_h == 0 ? 1 : in_h;
			if (fs) begin_frame();
			rend = (racc >> 16) - 1;
			if (orow < h && ocol < w && srow <= rend) begin
				k = ocol;
				cend = (cacc >> 16) - 1;
				if (scol <= cend) begin
					sa[k] = (sa[k] + a) & 32'hFFFFFF;
					sb[k] = (sb[k] + b) & 32'hFFFFFF;
					sc[k] = (sc[k] + c) & 32'hFFFFFF;
				end
				if (scol == cend) begin
					if (srow == rend) begin
						area = (rend + 1 - trow0) * (cend + 1 - tcol0);
						if (area == 0) area = 1;
						t.a = sa[k] / area;
						t.b = sb[k] / area;
						t.c = sc[k] / area;
						t.rdone = (k + 1 == w);
						t.fdone = t.rdone && (orow + 1 == h);
						pending = {pending, t};
					end
					ocol = k + 1;
					cacc = (cacc + step_of(c_step)) & 40'hFFFFFFFFFF;
					tcol0 = (cend + 1) & 32'h1FFF;
				end
			end
			if (scol + 1 >= iw) begin
				if (orow < h && srow == rend) begin
					orow++;
					racc = (racc + step_of(r_step)) & 40'hFFFFFFFFFF;
					trow0 = (rend + 1) & 32'h1FFF;
					clear_sums();
				end
				if (srow + 1 >= ih) begin_frame();
				else begin
					begin_row();
					srow = (srow + 1) & 32'h1FFF;
				end
			end else begin
				scol = (scol + 1) & 32'h1FFF;
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_avg(tile_avg_t got);
			tile_avg_t e;
			if (pending.size() == 0) begin
				report("unexpected result");
				return;
			end
			e = pending.pop_front();
			if (got.a !== e.a) report("avg_a mismatch");
			if (got.b !== e.b) report("avg_b mismatch");
			if (got.c !== e.c) report("avg_c mismatch");
			if (got.rdone !== e.rdone) report("row_done mismatch");
			if (got.fdone !== e.fdone) report("frame_done mismatch");
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, frame_start = 1'b0, out_stall = 1'b0, cfg_we = 1'b0;
	logic [7:0] chan_a = '0, chan_b = '0, chan_c = '0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	wire in_stall, out_valid, row_done, frame_done;
	wire [7:0] avg_a, avg_b, avg_c;
	tile_board board;
	bit stall_mode;

	area_average_image_downscaler_core i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		tile_avg_t got;
		if (arst_n && in_valid && !in_stall)
			board.note_pixel(chan_a, chan_b, chan_c, frame_start);
		if (arst_n && out_valid && !out_stall) begin
			got.a = avg_a; got.b = avg_b; got.c = avg_c;
			got.rdone = row_done; got.fdone = frame_done;
			board.check_avg(got);
		end
	end

	always @(negedge clk) begin
		if (stall_mode) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_reg(input int idx, input int unsigned v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_BITS'(idx);
		cfg_data <= CFG_DATA_BITS'(v);
		board.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [7:0] a, b, c, input logic fs);
		chan_a <= a; chan_b <= b; chan_c <= c; frame_start <= fs;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random(input int n, input int fs_pct);
		int left, burst, gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && left > 0) begin
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom),
					$urandom_range(0, 99) < fs_pct);
				burst--; left--;
			end
			gap = $urandom_range(0, 6);
			if (left > 0 && gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic settle();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(negedge clk); guard++;
		end
		repeat (40) @(negedge clk);
	endtask

	task automatic configure(input int unsigned iw, ih, ow, oh, rs, cs);
		write_reg(CFG_IN_WIDTH, iw);
		write_reg(CFG_IN_HEIGHT, ih);
		write_reg(CFG_OUT_WIDTH, ow);
		write_reg(CFG_OUT_HEIGHT, oh);
		write_reg(CFG_ROW_STEP, rs);
		write_reg(CFG_COL_STEP, cs);
	endtask

	initial begin
		int unsigned iw, ih;
		board = new();
		board.reset_regs();
		stall_mode = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		configure(4, 4, 2, 2, 131072, 131072);
		send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
		send_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
		send_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
		for (int i = 0; i < 13; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_pixel(8'h55, 8'hAA, 8'h01, 1'b1);
		settle();
		configure(3, 2, 0, 2, 0, 16777215);
		send_random(8, 0);
		settle();
		configure(0, 0, 2047, 8191, 65536, 65536);
		send_random(4, 0);
		settle();

		for (int phase = 0; phase < 12; phase++) begin
			iw = $urandom_range(1, 12);
			ih = $urandom_range(1, 8);
			stall_mode = phase[0];
			configure(iw, ih, $urandom_range(0, 14), $urandom_range(0, 9),
				$urandom_range(40000, 250000), $urandom_range(40000, 250000));
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
			send_random(60, phase % 3 == 2 ? 2 : 0);
			settle();
		end
		configure(460, 2, 1024, 2, 65536, 65536);
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		send_random(459, 0);
		settle();

		if (board.pending.size() == 0 && board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
sv/aad_pkg.sv
sv/aad_div.sv
sv/aad_dpath.sv
sv/aad_ctrl.sv
sv/area_average_image_downscaler_core.sv
verif/area_average_image_downscaler_core_tb.sv
